// ===== sv/uct_pkg.sv =====
// Shared types and codes for the update candidate table.
package uct_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 8;

  // Field widths
  localparam int OP_W   = 2;
  localparam int KEY_W  = 16;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK            = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_AVAILABLE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL          = 2'd2;

  // One stored candidate
  typedef struct packed {
    logic [KEY_W-1:0]  vendor;
    logic [KEY_W-1:0]  product;
    logic [WORD_W-1:0] version;
    logic [WORD_W-1:0] min_app;
    logic [WORD_W-1:0] max_app;
    logic [WORD_W-1:0] size;
  } entry_t;

  // Sequencer to table control
  typedef struct packed {
    logic wr_en;
    logic clr_all;
  } tbl_ctl_t;

endpackage

// ===== sv/update_candidate_table.sv =====
// Top level of the firmware update candidate table.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------
//   input    | in_opcode .. in_max_applicable | accepted when start && !busy
//   result   | out_status .. out_offered_size | out_valid strobe, one cycle
//
// Register and query walk the table one entry per cycle through one shared
// compare unit behind a registered memory read; a scan stops early when the
// key is found. Clear and unused opcodes answer from idle without a scan.
// Synchronous active-low reset drops every valid mark at once; no clearing
// pass is needed. The receiver cannot stall: each result is shown for
// exactly one cycle.
module update_candidate_table import uct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [KEY_W-1:0]  in_vendor_key,
  input  logic [KEY_W-1:0]  in_product_key,
  input  logic [WORD_W-1:0] in_version_in,
  input  logic [WORD_W-1:0] in_image_size_in,
  input  logic [WORD_W-1:0] in_min_applicable_in,
  input  logic [WORD_W-1:0] in_max_applicable_in,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [WORD_W-1:0] out_offered_version,
  output logic [WORD_W-1:0] out_offered_size
);

  localparam int IW = $clog2(ENTRIES);

  tbl_ctl_t      ctl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          rd_vld;

  // Scan sequencer
  uct_seq #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_vendor_key        (in_vendor_key),
    .in_product_key       (in_product_key),
    .in_version_in        (in_version_in),
    .in_image_size_in     (in_image_size_in),
    .in_min_applicable_in (in_min_applicable_in),
    .in_max_applicable_in (in_max_applicable_in),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slot_index       (out_slot_index),
    .out_offered_version  (out_offered_version),
    .out_offered_size     (out_offered_size),
    .ctl                  (ctl),
    .rd_addr              (rd_addr),
    .wr_addr              (wr_addr),
    .wr_data              (wr_data),
    .rd_data              (rd_data),
    .rd_vld               (rd_vld)
  );

  // Candidate storage
  uct_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

endmodule

// ===== sv/uct_store.sv =====
// Candidate storage: entry memory with registered read, valid bits in flops.
module uct_store import uct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_ctl_t      ctl,
  input  logic [IW-1:0] rd_addr,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  output entry_t        rd_data,
  output logic          rd_vld
);

  entry_t            mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid marks: cleared at once on reset or clear-all
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      valid_r <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld <= valid_r[rd_addr];
    end
  end

endmodule

// ===== sv/uct_seq.sv =====
// Scan sequencer: walks the table one entry a cycle through a shared key/version compare.
module uct_seq import uct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [KEY_W-1:0]  in_vendor_key,
  input  logic [KEY_W-1:0]  in_product_key,
  input  logic [WORD_W-1:0] in_version_in,
  input  logic [WORD_W-1:0] in_image_size_in,
  input  logic [WORD_W-1:0] in_min_applicable_in,
  input  logic [WORD_W-1:0] in_max_applicable_in,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [WORD_W-1:0] out_offered_version,
  output logic [WORD_W-1:0] out_offered_size,
  output tbl_ctl_t          ctl,
  output logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     wr_addr,
  output entry_t            wr_data,
  input  entry_t            rd_data,
  input  logic              rd_vld
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic              state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     eval_idx_r, eval_idx_nxt;
  logic              eval_vld_r, eval_vld_nxt;
  logic              have_empty_r, have_empty_nxt;
  logic [IW-1:0]     empty_idx_r, empty_idx_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  entry_t            item_r, item_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WORD_W-1:0] over_r, over_nxt;
  logic [WORD_W-1:0] osize_r, osize_nxt;
  logic              key_hit;
  logic              applies;

  // Shared compare unit on the entry read last cycle
  assign key_hit = rd_vld && (rd_data.vendor == item_r.vendor)
                   && (rd_data.product == item_r.product);
  assign applies = (rd_data.version > item_r.version)
                   && (rd_data.max_app >= item_r.version)
                   && (rd_data.min_app <= item_r.version);

  assign busy      = (state_r == S_SCAN);
  assign rd_addr   = idx_r;
  assign wr_data   = item_r;
  assign out_valid = out_valid_r;
  assign out_status          = status_r;
  assign out_slot_index      = slot_r;
  assign out_offered_version = over_r;
  assign out_offered_size    = osize_r;

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    eval_idx_nxt   = eval_idx_r;
    eval_vld_nxt   = eval_vld_r;
    have_empty_nxt = have_empty_r;
    empty_idx_nxt  = empty_idx_r;
    op_nxt         = op_r;
    item_nxt       = item_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    over_nxt       = over_r;
    osize_nxt      = osize_r;
    ctl            = '0;
    wr_addr        = eval_idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt          = in_opcode;
          item_nxt.vendor  = in_vendor_key;
          item_nxt.product = in_product_key;
          item_nxt.version = in_version_in;
          item_nxt.min_app = in_min_applicable_in;
          item_nxt.max_app = in_max_applicable_in;
          item_nxt.size    = in_image_size_in;
          idx_nxt          = '0;
          eval_vld_nxt     = 1'b0;
          have_empty_nxt   = 1'b0;
          status_nxt       = ST_OK;
          slot_nxt         = '0;
          over_nxt         = '0;
          osize_nxt        = '0;
          case (in_opcode)
            OP_REGISTER, OP_QUERY: begin
              state_nxt = S_SCAN;
            end
            OP_CLEAR: begin
              ctl.clr_all   = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue the next read while the previous entry is compared
        eval_vld_nxt = 1'b1;
        eval_idx_nxt = idx_r;
        if (idx_r != LAST) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (eval_vld_r) begin
          if (key_hit) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            if (op_r == OP_REGISTER) begin
              ctl.wr_en = 1'b1;
              slot_nxt  = SLOT_W'(eval_idx_r);
            end else if (applies) begin
              slot_nxt  = SLOT_W'(eval_idx_r);
              over_nxt  = rd_data.version;
              osize_nxt = rd_data.size;
            end else begin
              status_nxt = ST_NOT_AVAILABLE;
            end
          end else if (eval_idx_r == LAST) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            if (op_r == OP_REGISTER) begin
              if (have_empty_r) begin
                ctl.wr_en = 1'b1;
                wr_addr   = empty_idx_r;
                slot_nxt  = SLOT_W'(empty_idx_r);
              end else if (!rd_vld) begin
                ctl.wr_en = 1'b1;
                slot_nxt  = SLOT_W'(eval_idx_r);
              end else begin
                status_nxt = ST_FULL;
              end
            end else begin
              status_nxt = ST_NOT_AVAILABLE;
            end
          end else if (!rd_vld && !have_empty_r) begin
            // Remember the lowest free slot
            have_empty_nxt = 1'b1;
            empty_idx_nxt  = eval_idx_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      eval_vld_r  <= 1'b0;
      have_empty_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      eval_vld_r  <= eval_vld_nxt;
      have_empty_r <= have_empty_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    op_r        <= op_nxt;
    item_r      <= item_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    over_r      <= over_nxt;
    osize_r     <= osize_nxt;
  end

endmodule

// ===== sim/update_candidate_table_check.sv =====
`timescale 1ns / 1ps
// Checker for the update candidate table: tracks the table and compares each result item.
module update_candidate_table_check import uct_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [KEY_W-1:0]  in_vendor_key,
  input  logic [KEY_W-1:0]  in_product_key,
  input  logic [WORD_W-1:0] in_version_in,
  input  logic [WORD_W-1:0] in_image_size_in,
  input  logic [WORD_W-1:0] in_min_applicable_in,
  input  logic [WORD_W-1:0] in_max_applicable_in,
  input  logic              out_valid,
  input  logic [ST_W-1:0]   out_status,
  input  logic [SLOT_W-1:0] out_slot_index,
  input  logic [WORD_W-1:0] out_offered_version,
  input  logic [WORD_W-1:0] out_offered_size,
  output int                fail_count,
  output int                offers_pending
);

  // One answer of the table
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] version;
    logic [WORD_W-1:0] size;
  } offer_t;

  // Shadow copy of the candidate table
  logic   cand_valid [ENTRIES];
  entry_t cand       [ENTRIES];
  offer_t expected_offers [$];

  // Apply one request to the shadow table and return the answer it gives
  function automatic offer_t serve_request(
    input logic [OP_W-1:0]   op,
    input logic [KEY_W-1:0]  vend,
    input logic [KEY_W-1:0]  prod,
    input logic [WORD_W-1:0] ver,
    input logic [WORD_W-1:0] size,
    input logic [WORD_W-1:0] lo,
    input logic [WORD_W-1:0] hi
  );
    offer_t res;
    int     hit;
    int     free_slot;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    // first valid entry with the key, and the lowest empty slot
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && cand_valid[i] && cand[i].vendor == vend && cand[i].product == prod)
        hit = i;
      if (free_slot < 0 && !cand_valid[i])
        free_slot = i;
    end
    if (op == OP_REGISTER) begin
      if (hit < 0)
        hit = free_slot;
      if (hit < 0) begin
        res.status = ST_FULL;
      end else begin
        cand_valid[hit] = 1'b1;
        cand[hit]       = '{vendor: vend, product: prod, version: ver,
                            min_app: lo, max_app: hi, size: size};
        res.status      = ST_OK;
        res.slot        = SLOT_W'(hit);
      end
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++)
        cand_valid[i] = 1'b0;
      res.status = ST_OK;
    end else if (op == OP_QUERY) begin
      res.status = ST_NOT_AVAILABLE;
      // newer than the requestor and requestor within the applicable range
      if (hit >= 0 && cand[hit].version > ver &&
          cand[hit].max_app >= ver && cand[hit].min_app <= ver) begin
        res.status  = ST_OK;
        res.slot    = SLOT_W'(hit);
        res.version = cand[hit].version;
        res.size    = cand[hit].size;
      end
    end
    return res;
  endfunction

  // Compare result items against the oldest expectation, then record new items
  always @(posedge clk) begin
    offer_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++)
        cand_valid[i] = 1'b0;
      expected_offers.delete();
    end else begin
      if (out_valid) begin
        if (expected_offers.size() == 0) begin
          $error("out_valid: result item with none expected");
          fail_count++;
        end else begin
          want = expected_offers.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_slot_index !== want.slot) begin
            $error("out_slot_index: expected %0d, actual %0d", want.slot, out_slot_index);
            fail_count++;
          end
          if (out_offered_version !== want.version) begin
            $error("out_offered_version: expected %h, actual %h",
                   want.version, out_offered_version);
            fail_count++;
          end
          if (out_offered_size !== want.size) begin
            $error("out_offered_size: expected %h, actual %h", want.size, out_offered_size);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_offers.push_back(serve_request(in_opcode, in_vendor_key, in_product_key,
                                                in_version_in, in_image_size_in,
                                                in_min_applicable_in, in_max_applicable_in));
    end
    offers_pending = expected_offers.size();
  end

endmodule

// ===== sim/update_candidate_table_test.sv =====
`timescale 1ns / 1ps
// Regression top for the update candidate table: stimulus, reset and verdict.
module update_candidate_table_test;
  import uct_pkg::*;

  localparam int ENTRIES      = 8;
  localparam int KEY_POOL     = 11;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES  = '1;

  logic              clk                  = 1'b0;
  logic              rst_n                = 1'b0;
  logic              start                = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_opcode            = '0;
  logic [KEY_W-1:0]  in_vendor_key        = '0;
  logic [KEY_W-1:0]  in_product_key       = '0;
  logic [WORD_W-1:0] in_version_in        = '0;
  logic [WORD_W-1:0] in_image_size_in     = '0;
  logic [WORD_W-1:0] in_min_applicable_in = '0;
  logic [WORD_W-1:0] in_max_applicable_in = '0;
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [SLOT_W-1:0] out_slot_index;
  logic [WORD_W-1:0] out_offered_version;
  logic [WORD_W-1:0] out_offered_size;
  int                fail_count;
  int                offers_pending;

  // No gaps between items while set
  bit steady = 1'b0;

  // Keys used by the random part, with the last values registered under each
  logic [KEY_W-1:0]  pool_vendor  [KEY_POOL];
  logic [KEY_W-1:0]  pool_product [KEY_POOL];
  logic [WORD_W-1:0] pool_lo      [KEY_POOL];
  logic [WORD_W-1:0] pool_hi      [KEY_POOL];
  logic [WORD_W-1:0] pool_ver     [KEY_POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  update_candidate_table #(.ENTRIES(ENTRIES)) DUT (.*);

  update_candidate_table_check #(.ENTRIES(ENTRIES)) check (.*);

  // Run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("update_candidate_table regression: fail");
    $finish;
  end

  // Idle cycles before the next item: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one item at a falling edge and hold it until accepted
  task automatic send_item(
    input logic [OP_W-1:0]   op,
    input logic [KEY_W-1:0]  vend,
    input logic [KEY_W-1:0]  prod,
    input logic [WORD_W-1:0] ver,
    input logic [WORD_W-1:0] size,
    input logic [WORD_W-1:0] lo,
    input logic [WORD_W-1:0] hi
  );
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode            <= op;
    in_vendor_key        <= vend;
    in_product_key       <= prod;
    in_version_in        <= ver;
    in_image_size_in     <= size;
    in_min_applicable_in <= lo;
    in_max_applicable_in <= hi;
    start                <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  initial begin
    int sent;
    int k;
    int kind;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] ver;
    logic [WORD_W-1:0] qv;

    // key pool: extremes, a shared vendor and a shared product among them
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_vendor[i]  = KEY_W'($urandom);
      pool_product[i] = KEY_W'($urandom);
      pool_lo[i]      = $urandom;
      pool_hi[i]      = $urandom;
      pool_ver[i]     = $urandom;
    end
    pool_vendor[0]  = '0;
    pool_product[0] = '0;
    pool_vendor[1]  = '1;
    pool_product[1] = '1;
    pool_vendor[2]  = pool_vendor[1];
    pool_product[3] = pool_product[0];

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: lookups on an empty table, range edges, overwrite, full table, clear
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 16'h0000, 16'h0000, ALL_ONES, ALL_ONES, 32'd0, ALL_ONES);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_QUERY, 16'h0000, 16'h0000, ALL_ONES, 32'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 16'hFFFF, 16'hFFFF, 32'd100, 32'h1234_5678, 32'd10, 32'd20);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 32'd10, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 32'd20, 32'd0, 32'd0, 32'd0);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 32'd9, 32'd0, 32'd0, 32'd0);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 32'd21, 32'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 16'hFFFF, 16'hFFFF, 32'd5, 32'd77, 32'd10, 32'd20);
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, 32'd10, 32'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 16'hFFFF, 16'h0000, 32'd2, 32'd3, 32'd0, 32'd1);
    send_item(OP_QUERY, 16'h0000, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < ENTRIES - 3; i++)
      send_item(OP_REGISTER, KEY_W'(16'h1000 + i), KEY_W'(16'h2000 + i), 32'd50 + i,
                $urandom, 32'd0, 32'd40);
    // table full: a new key is refused, an existing one is still rewritten
    send_item(OP_REGISTER, 16'h3000, 16'h3000, 32'd9, 32'd9, 32'd0, 32'd8);
    send_item(OP_REGISTER, 16'h0000, 16'h0000, 32'd8, 32'd4096, 32'd1, 32'd7);
    send_item(OP_UNUSED, 16'h1000, 16'h2000, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_item(OP_QUERY, 16'h0000, 16'h0000, 32'd1, 32'd0, 32'd0, 32'd0);
    send_item(OP_REGISTER, 16'hFFFF, 16'hFFFF, 32'd30, 32'd31, 32'd0, 32'd29);

    // Random: mostly register and query on pooled keys, some clears and noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 50 == 0)
        steady = ($urandom_range(0, 3) == 0);
      k    = $urandom_range(0, KEY_POOL - 1);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        case ($urandom_range(0, 9))
          0: begin
            lo  = '0;
            hi  = ALL_ONES;
            ver = ALL_ONES;
          end
          1: begin
            lo  = $urandom;
            hi  = $urandom;
            ver = $urandom;
          end
          // empty range: never applicable
          2: begin
            hi  = $urandom_range(0, 1000);
            lo  = hi + 1 + $urandom_range(0, 1000);
            ver = $urandom;
          end
          // offered version inside the range
          3: begin
            lo  = $urandom;
            hi  = lo + $urandom_range(0, 1000);
            if (hi < lo)
              hi = ALL_ONES;
            ver = lo + (hi - lo) / 2;
          end
          default: begin
            lo  = $urandom;
            hi  = lo + $urandom_range(0, 1000);
            if (hi < lo)
              hi = ALL_ONES;
            ver = hi + $urandom_range(0, 3);
            if (ver < hi)
              ver = ALL_ONES;
          end
        endcase
        pool_lo[k]  = lo;
        pool_hi[k]  = hi;
        pool_ver[k] = ver;
        send_item(OP_REGISTER, pool_vendor[k], pool_product[k], ver, $urandom, lo, hi);
      end else if (kind < 80) begin
        // requestor version on the edges of the stored entry
        case ($urandom_range(0, 9))
          0:       qv = pool_lo[k] - 1;
          1:       qv = pool_lo[k];
          2:       qv = pool_hi[k];
          3:       qv = pool_hi[k] + 1;
          4:       qv = pool_ver[k] - 1;
          5:       qv = pool_ver[k];
          6:       qv = pool_ver[k] + 1;
          7:       qv = $urandom;
          8:       qv = '0;
          default: qv = ALL_ONES;
        endcase
        send_item(OP_QUERY, pool_vendor[k], pool_product[k], qv, $urandom, $urandom,
                  $urandom);
      end else if (kind < 83) begin
        send_item(OP_CLEAR, KEY_W'($urandom), KEY_W'($urandom), $urandom, $urandom,
                  $urandom, $urandom);
      end else begin
        op = OP_W'($urandom_range(0, 3));
        send_item(op, KEY_W'($urandom), KEY_W'($urandom), $urandom, $urandom, $urandom,
                  $urandom);
        // ignored items do not count
        if (op == OP_UNUSED)
          sent--;
      end
      sent++;
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain, then allow one full table walk for any stray result
    while (offers_pending != 0)
      @(negedge clk);
    repeat (ENTRIES + 4) @(negedge clk);

    if (fail_count == 0 && offers_pending == 0)
      $display("update_candidate_table regression: pass");
    else
      $display("update_candidate_table regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/uct_pkg.sv
sv/uct_store.sv
sv/uct_seq.sv
sv/update_candidate_table.sv
sim/update_candidate_table_check.sv
sim/update_candidate_table_test.sv
